// ----- hdl/bdq_pkg.sv -----
// shared constants, codes and slot arithmetic for the bounded deque
package bdq_pkg;

    localparam int CAPACITY = 64;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int SUM_W    = CNT_W + 1;
    localparam int VAL_W    = 32;
    localparam int FUNC_W   = 3;
    localparam int STAT_W   = 2;
    localparam int OCNT_W   = 7;
    localparam int IN_W     = 40;
    localparam int OUT_W    = 48;

    typedef logic [FUNC_W-1:0] t_func;
    typedef logic [STAT_W-1:0] t_status;
    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [CNT_W-1:0]  t_cnt;
    typedef logic [VAL_W-1:0]  t_val;

    localparam t_func F_INS_FRONT = 3'd0;
    localparam t_func F_INS_BACK  = 3'd1;
    localparam t_func F_REM_FRONT = 3'd2;
    localparam t_func F_REM_BACK  = 3'd3;
    localparam t_func F_REM_KEY   = 3'd4;

    localparam t_status ST_OK        = 2'd0;
    localparam t_status ST_EMPTY     = 2'd1;
    localparam t_status ST_NOT_FOUND = 2'd2;
    localparam t_status ST_FULL      = 2'd3;

    // physical slot of list position pos, front at fp
    function automatic t_addr slot_of(input t_addr fp, input t_cnt pos);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(fp) + SUM_W'(pos);
        if (sum >= SUM_W'(CAPACITY)) begin
            sum = sum - SUM_W'(CAPACITY);
        end
        return sum[ADDR_W-1:0];
    endfunction

    function automatic t_addr slot_inc(input t_addr a);
        return (a == ADDR_W'(CAPACITY - 1)) ? '0 : a + 1'b1;
    endfunction

    function automatic t_addr slot_dec(input t_addr a);
        return (a == '0) ? ADDR_W'(CAPACITY - 1) : a - 1'b1;
    endfunction

endpackage

// ----- hdl/bdq_ram.sv -----
// simple dual-port ram, one write and one registered read per cycle
module bdq_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hdl/bounded_deque_with_delete_by_key_core.sv -----
// bounded deque with removal by key: control sequencer around the entry ram
//
//  port group      dir   word fields (lsb first)
//  s_axis_*        in    func[2:0], value[34:3], zero fill to 40 bits
//  m_axis_*        out   status[1:0], item_value[33:2], entry_count[40:34], zero fill
//
// insert and ignored codes go from decode straight to the output state, front/back removal waits for its ram read.
// removal by key makes one ram read per list position for the search, then one read and
// one write per later entry while closing the gap.
// a new word is taken while the previous result still waits at the output register.
// i_rst_n (synchronous) clears pointer, count and control; the ram needs no clearing.
module bounded_deque_with_delete_by_key_core
    import bdq_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [IN_W-1:0]  s_axis_tdata,   // func, value
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [OUT_W-1:0] m_axis_tdata    // status, item_value, entry_count
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECODE = 3'd1;
    localparam logic [2:0] S_RDWAIT = 3'd2;
    localparam logic [2:0] S_SEARCH = 3'd3;
    localparam logic [2:0] S_SHIFT  = 3'd4;
    localparam logic [2:0] S_OUT    = 3'd5;

    logic [2:0] r_state, n_state;
    t_addr      r_fp, n_fp;
    t_cnt       r_count, n_count;
    t_func      r_func, n_func;
    t_val       r_val, n_val;
    t_cnt       r_pos, n_pos;
    t_cnt       r_chk_pos, n_chk_pos;
    t_cnt       r_wpos, n_wpos;
    logic       r_sh_valid, n_sh_valid;
    t_status    r_res_status, n_res_status;
    t_val       r_res_item, n_res_item;
    logic       r_ovalid, n_ovalid;
    t_status    r_ostatus, n_ostatus;
    t_val       r_oitem, n_oitem;
    t_cnt       r_ocount, n_ocount;

    logic  ram_we;
    t_addr ram_waddr;
    t_val  ram_wdata;
    t_addr ram_raddr;
    t_val  ram_rdata;
    t_cnt  rd_pos;
    t_cnt  last_pos;
    logic  is_full;
    logic  is_empty;
    logic  in_fire;
    logic  out_free;

    bdq_ram #(
        .DEPTH(CAPACITY),
        .WIDTH(VAL_W),
        .AW   (ADDR_W)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    assign is_full  = (r_count == CNT_W'(CAPACITY));
    assign is_empty = (r_count == '0);
    assign last_pos = r_count - 1'b1;
    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign out_free = !r_ovalid || m_axis_tready;

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {{(OUT_W - STAT_W - VAL_W - OCNT_W){1'b0}},
                            OCNT_W'(r_ocount), r_oitem, r_ostatus};

    // back removal reads the last position, everything else walks r_pos
    assign rd_pos    = (r_state == S_DECODE && r_func == F_REM_BACK) ? last_pos : r_pos;
    assign ram_raddr = slot_of(r_fp, rd_pos);

    always_comb begin
        n_state      = r_state;
        n_fp         = r_fp;
        n_count      = r_count;
        n_func       = r_func;
        n_val        = r_val;
        n_pos        = r_pos;
        n_chk_pos    = r_chk_pos;
        n_wpos       = r_wpos;
        n_sh_valid   = r_sh_valid;
        n_res_status = r_res_status;
        n_res_item   = r_res_item;
        n_ovalid     = r_ovalid;
        n_ostatus    = r_ostatus;
        n_oitem      = r_oitem;
        n_ocount     = r_ocount;
        ram_we       = 1'b0;
        ram_waddr    = slot_of(r_fp, r_wpos);
        ram_wdata    = ram_rdata;

        if (r_ovalid && m_axis_tready) begin
            n_ovalid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_func  = s_axis_tdata[FUNC_W-1:0];
                    n_val   = s_axis_tdata[FUNC_W +: VAL_W];
                    n_pos   = '0;
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                n_res_status = ST_OK;
                n_res_item   = '0;
                n_state      = S_OUT;
                priority if (r_func == F_INS_FRONT || r_func == F_INS_BACK) begin
                    if (is_full) begin
                        n_res_status = ST_FULL;
                    end else begin
                        ram_we     = 1'b1;
                        ram_wdata  = r_val;
                        n_res_item = r_val;
                        n_count    = r_count + 1'b1;
                        if (r_func == F_INS_FRONT) begin
                            ram_waddr = slot_dec(r_fp);
                            n_fp      = slot_dec(r_fp);
                        end else begin
                            ram_waddr = slot_of(r_fp, r_count);
                        end
                    end
                end else if (r_func == F_REM_FRONT || r_func == F_REM_BACK
                             || r_func == F_REM_KEY) begin
                    if (is_empty) begin
                        n_res_status = ST_EMPTY;
                    end else if (r_func == F_REM_KEY) begin
                        // position 0 is being read now
                        n_pos     = CNT_W'(1);
                        n_chk_pos = '0;
                        n_state   = S_SEARCH;
                    end else begin
                        n_state = S_RDWAIT;
                    end
                end else begin
                    // unused codes: nothing changes
                    n_res_status = ST_OK;
                end
            end
            S_RDWAIT: begin
                n_res_status = ST_OK;
                n_res_item   = ram_rdata;
                n_count      = r_count - 1'b1;
                if (r_func == F_REM_FRONT) begin
                    n_fp = slot_inc(r_fp);
                end
                n_state = S_OUT;
            end
            S_SEARCH: begin
                n_pos     = r_pos + 1'b1;
                n_chk_pos = r_pos;
                priority if (ram_rdata == r_val) begin
                    n_res_status = ST_OK;
                    n_res_item   = ram_rdata;
                    if (r_chk_pos == '0) begin
                        n_fp    = slot_inc(r_fp);
                        n_count = r_count - 1'b1;
                        n_state = S_OUT;
                    end else if (r_chk_pos == last_pos) begin
                        n_count = r_count - 1'b1;
                        n_state = S_OUT;
                    end else begin
                        // close the gap: read p+1 on entering the shift, write it to p in the cycle after
                        n_pos      = r_chk_pos + 1'b1;
                        n_wpos     = r_chk_pos;
                        n_sh_valid = 1'b0;
                        n_state    = S_SHIFT;
                    end
                end else if (r_chk_pos == last_pos) begin
                    n_res_status = ST_NOT_FOUND;
                    n_res_item   = '0;
                    n_state      = S_OUT;
                end else begin
                    n_state = S_SEARCH;
                end
            end
            S_SHIFT: begin
                n_pos      = r_pos + 1'b1;
                n_sh_valid = 1'b1;
                if (r_sh_valid) begin
                    ram_we    = 1'b1;
                    ram_waddr = slot_of(r_fp, r_wpos);
                    ram_wdata = ram_rdata;
                    n_wpos    = r_wpos + 1'b1;
                    if (r_wpos == r_count - CNT_W'(2)) begin
                        n_count = r_count - 1'b1;
                        n_state = S_OUT;
                    end
                end
            end
            S_OUT: begin
                if (out_free) begin
                    n_ovalid  = 1'b1;
                    n_ostatus = r_res_status;
                    n_oitem   = r_res_item;
                    n_ocount  = r_count;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_fp       <= '0;
            r_count    <= '0;
            r_ovalid   <= 1'b0;
            r_sh_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_fp       <= n_fp;
            r_count    <= n_count;
            r_ovalid   <= n_ovalid;
            r_sh_valid <= n_sh_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_func       <= n_func;
        r_val        <= n_val;
        r_pos        <= n_pos;
        r_chk_pos    <= n_chk_pos;
        r_wpos       <= n_wpos;
        r_res_status <= n_res_status;
        r_res_item   <= n_res_item;
        r_ostatus    <= n_ostatus;
        r_oitem      <= n_oitem;
        r_ocount     <= n_ocount;
    end

endmodule
